// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. They are clocked on clk and disabled
// while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== sv/icymss_pkg.sv =====
// ----------------------------------------------------------------------------
// ICY metadata strip package
// Widths, the Ogg capture signature and the item type that moves between the
// front end, the queue and the back end.
// ----------------------------------------------------------------------------
package icymss_pkg;

	localparam int unsigned DATA_W     = 8;
	localparam int unsigned INTERVAL_W = 21;
	localparam int unsigned SKIP_W     = 12;
	localparam int unsigned FIFO_DEPTH = 4;

	// ASCII "OggS", first byte first.
	localparam logic [DATA_W-1:0] OGG_SIG [4] = '{8'h4F, 8'h67, 8'h67, 8'h53};

	// One audio byte with its valid flag.
	typedef struct packed {
		logic              valid;
		logic [DATA_W-1:0] data;
	} byte_xfer_t;

endpackage

// ===== sv/icymss_front.sv =====
// ----------------------------------------------------------------------------
// ICY metadata strip front end
// Accepts stream bytes, tracks the metadata interval and the length-byte
// skip count, and forwards audio bytes to the queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module icymss_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [icymss_pkg::INTERVAL_W-1:0]      cfg_data,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [icymss_pkg::DATA_W-1:0]          s_tdata,
	input  logic                                   q_full,
	output icymss_pkg::byte_xfer_t                 push
);
	import icymss_pkg::*;

	logic [INTERVAL_W-1:0] interval_q;
	logic [INTERVAL_W-1:0] audio_left_q;
	logic [SKIP_W-1:0]     meta_skip_q;
	logic                  accept;
	logic                  is_audio;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	// Classify the current byte: audio unless stripping is on and it is a
	// length byte or falls inside a metadata block.
	always_comb begin
		if (interval_q == '0) begin
			is_audio = 1'b1;
		end else if (meta_skip_q != '0) begin
			is_audio = 1'b0;
		end else if (audio_left_q == '0) begin
			is_audio = 1'b0;
		end else begin
			is_audio = 1'b1;
		end
	end

	assign push.valid = accept && is_audio;
	assign push.data  = s_tdata;

	// Interval and skip counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q   <= '0;
			audio_left_q <= '0;
			meta_skip_q  <= '0;
		end else if (cfg_we) begin
			interval_q   <= cfg_data;
			audio_left_q <= cfg_data;
			meta_skip_q  <= '0;
		end else if (accept) begin
			if (interval_q == '0) begin
				meta_skip_q <= '0;
			end else if (meta_skip_q != '0) begin
				meta_skip_q <= meta_skip_q - SKIP_W'(1);
				if (meta_skip_q == SKIP_W'(1)) begin
					audio_left_q <= interval_q;
				end
			end else if (audio_left_q == '0) begin
				// Length byte: the block is sixteen bytes per unit.
				meta_skip_q <= {s_tdata, 4'b0000};
				if (s_tdata == '0) begin
					audio_left_q <= interval_q;
				end
			end else begin
				audio_left_q <= audio_left_q - INTERVAL_W'(1);
			end
		end
	end

	// A pending skip only exists while stripping is enabled.
	`ASSERT_AT(a_skip_needs_interval, (meta_skip_q != '0) |-> (interval_q != '0),
		"metadata skip pending with stripping disabled")

endmodule

// ===== sv/icymss_fifo.sv =====
// ----------------------------------------------------------------------------
// ICY metadata strip queue
// Small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module icymss_fifo #(
	parameter int unsigned DEPTH = icymss_pkg::FIFO_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  icymss_pkg::byte_xfer_t push,
	output logic                   full,
	output icymss_pkg::byte_xfer_t head,
	input  logic                   pop
);
	import icymss_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.data  = mem_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// A push offered while full would be lost.
	`ASSERT_NEVER(a_no_overflow, push.valid && full, "push into full queue")

endmodule

// ===== sv/icymss_back.sv =====
// ----------------------------------------------------------------------------
// ICY metadata strip back end
// Holds the first four audio bytes, classifies them against "OggS", releases
// them as four items and then passes later audio bytes with the flag.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module icymss_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  icymss_pkg::byte_xfer_t        head,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [icymss_pkg::DATA_W-1:0] m_tdata,
	output logic                          m_tuser,
	output logic                          m_tlast
);
	import icymss_pkg::*;

	logic [DATA_W-1:0] store_q [4];
	logic [1:0]        sniff_count_q;
	logic              sniff_done_q;
	logic              ogg_flag_q;
	logic              rel_active_q;
	logic [1:0]        rel_idx_q;
	logic              m_tvalid_q;
	logic [DATA_W-1:0] m_tdata_q;
	logic              m_tuser_q;
	logic              m_tlast_q;
	logic              out_free;
	logic              take;
	logic              sig_match;

	assign out_free = !m_tvalid_q || m_tready;
	assign pop      = head.valid && !rel_active_q && (!sniff_done_q || out_free);
	assign take     = pop;

	assign sig_match = (store_q[0] == OGG_SIG[0]) && (store_q[1] == OGG_SIG[1]) &&
		(store_q[2] == OGG_SIG[2]) && (head.data == OGG_SIG[3]);

	// Prefix capture and classification.
	always_ff @(posedge clk) begin
		if (take && !sniff_done_q) begin
			store_q[sniff_count_q] <= head.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sniff_count_q <= '0;
			sniff_done_q  <= 1'b0;
			ogg_flag_q    <= 1'b0;
			rel_active_q  <= 1'b0;
			rel_idx_q     <= '0;
		end else begin
			if (take && !sniff_done_q) begin
				sniff_count_q <= sniff_count_q + 2'd1;
				if (sniff_count_q == 2'd3) begin
					ogg_flag_q   <= sig_match;
					sniff_done_q <= 1'b1;
					rel_active_q <= 1'b1;
					rel_idx_q    <= '0;
				end
			end
			if (rel_active_q && out_free) begin
				rel_idx_q <= rel_idx_q + 2'd1;
				if (rel_idx_q == 2'd3) begin
					rel_active_q <= 1'b0;
				end
			end
		end
	end

	// Output register: release items first, then live audio.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (rel_active_q && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (take && sniff_done_q) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rel_active_q && out_free) begin
			m_tdata_q <= store_q[rel_idx_q];
			m_tuser_q <= ogg_flag_q;
			m_tlast_q <= (rel_idx_q == 2'd3);
		end else if (take && sniff_done_q) begin
			m_tdata_q <= head.data;
			m_tuser_q <= ogg_flag_q;
			m_tlast_q <= 1'b1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// Outside a release every item ends its own run.
	`ASSERT_AT(a_last_outside_release, (m_tvalid_q && !rel_active_q) |-> m_tlast_q,
		"non-final item outside prefix release")
	// A release only follows a completed classification.
	`ASSERT_AT(a_release_after_sniff, rel_active_q |-> sniff_done_q,
		"release active before classification")

endmodule

// ===== sv/icy_metadata_strip_and_ogg_sniff.sv =====
// ----------------------------------------------------------------------------
// ICY metadata strip and Ogg sniff, top level
// Channel   Dir  Handshake          Contents
// s_*       in   tvalid/tready      tdata[7:0] data_byte
// m_*       out  tvalid/tready      tdata[7:0] audio_byte, tuser is_ogg,
//                                   tlast run_last
// cfg_*     in   cfg_we             cfg_data[20:0] interval
//
// One input item per cycle while the queue is not full; a byte passes the front
// end in the cycle it is accepted. Audio bytes after the prefix enter the output
// register as they are popped; the four-byte prefix release holds the back end
// until all four items are loaded, and the front end accepts until the queue
// (FIFO_DEPTH entries) is full. Reset clears counters and control flags.
// ----------------------------------------------------------------------------
module icy_metadata_strip_and_ogg_sniff #(
	parameter int unsigned FIFO_DEPTH = icymss_pkg::FIFO_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [icymss_pkg::INTERVAL_W-1:0] cfg_data,   // interval
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [icymss_pkg::DATA_W-1:0]     s_tdata,    // [7:0] data_byte
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [icymss_pkg::DATA_W-1:0]     m_tdata,    // [7:0] audio_byte
	output logic                              m_tuser,    // [0] is_ogg
	output logic                              m_tlast
);
	import icymss_pkg::*;

	byte_xfer_t push;
	byte_xfer_t head;
	logic       q_full;
	logic       pop;

	// Classification of raw bytes.
	icymss_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.push     (push)
	);

	// Decoupling queue.
	icymss_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	// Sniffing and output.
	icymss_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
